// ----- design/lockord_pkg.sv -----
package lockord_pkg;

  localparam int THREADS      = 8;
  localparam int HELD_SLOTS   = 16;
  localparam int CLASSES      = 64;
  localparam int LOCK_ID_BITS = 32;
  localparam int COUNT_BITS   = 16;

  localparam int THR_BITS       = $clog2(THREADS);
  localparam int SLOT_BITS      = $clog2(HELD_SLOTS);
  localparam int CLS_BITS       = $clog2(CLASSES);
  localparam int LVL_BITS       = 6;
  localparam int STATUS_BITS    = 3;
  localparam int HELD_DEPTH     = THREADS * HELD_SLOTS;
  localparam int HELD_ADDR_BITS = THR_BITS + SLOT_BITS;

  localparam logic [LVL_BITS-1:0]   LEVEL_MAX  = {LVL_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_CEIL = {COUNT_BITS{1'b1}};

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_REVERSAL = 3'd1,
    ST_NOT_HELD = 3'd2,
    ST_SPIN     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [LOCK_ID_BITS-1:0] lock_id;
    logic [CLS_BITS-1:0]     cls;
    logic [LVL_BITS-1:0]     lvl;
    logic [COUNT_BITS-1:0]   count;
  } held_t;

  typedef struct packed {
    logic                      we;
    logic [HELD_ADDR_BITS-1:0] addr;
    held_t                     data;
  } held_wr_t;

  typedef struct packed {
    logic                we;
    logic [CLS_BITS-1:0] addr;
    logic [LVL_BITS-1:0] data;
  } cls_wr_t;

  typedef struct packed {
    status_t               status;
    logic [LVL_BITS-1:0]   class_level;
    logic [COUNT_BITS-1:0] hold_count;
    logic [CLS_BITS-1:0]   conflict_class;
  } rsp_t;

endpackage

// ----- design/lockord_if.sv -----
interface lockord_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [lockord_pkg::THR_BITS-1:0]      thread_id;
  logic [lockord_pkg::LOCK_ID_BITS-1:0]  lock_id;
  logic [lockord_pkg::CLS_BITS-1:0]      class_id;
  logic                                  spinlocks_held;

  modport source (output valid, cmd, thread_id, lock_id, class_id, spinlocks_held,
                  input ready);
  modport sink   (input valid, cmd, thread_id, lock_id, class_id, spinlocks_held,
                  output ready);
endinterface

interface lockord_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [lockord_pkg::STATUS_BITS-1:0]   status;
  logic [lockord_pkg::LVL_BITS-1:0]      class_level;
  logic [lockord_pkg::COUNT_BITS-1:0]    hold_count;
  logic [lockord_pkg::CLS_BITS-1:0]      conflict_class;

  modport source (output valid, status, class_level, hold_count, conflict_class,
                  input ready);
  modport sink   (input valid, status, class_level, hold_count, conflict_class,
                  output ready);
endinterface

// ----- design/lockord_ram.sv -----
module lockord_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lockord_ctrl.sv -----
module lockord_ctrl (
  input  logic                                       clk,
  input  logic                                       rst_n,
  lockord_req_if.sink                                req,
  output logic [lockord_pkg::HELD_ADDR_BITS-1:0]     held_raddr,
  input  lockord_pkg::held_t                         held_rdata,
  output lockord_pkg::held_wr_t                      held_wr,
  output logic [lockord_pkg::CLS_BITS-1:0]           cls_raddr,
  input  logic [lockord_pkg::LVL_BITS-1:0]           cls_rdata,
  output lockord_pkg::cls_wr_t                       cls_wr,
  output logic                                       res_valid,
  input  logic                                       res_take,
  output lockord_pkg::rsp_t                          res
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                                    cmd_r;
  logic                                    spin_r;
  logic [lockord_pkg::THR_BITS-1:0]        thr_r;
  logic [lockord_pkg::LOCK_ID_BITS-1:0]    id_r;
  logic [lockord_pkg::CLS_BITS-1:0]        cls_r;

  logic [lockord_pkg::SLOT_BITS-1:0]       chk_r;
  logic                                    found_r;
  logic [lockord_pkg::SLOT_BITS-1:0]       found_slot_r;
  lockord_pkg::held_t                      found_word_r;
  logic                                    any_r;
  logic [lockord_pkg::LVL_BITS-1:0]        maxl_r;
  logic                                    rev_r;
  logic [lockord_pkg::CLS_BITS-1:0]        conflict_r;
  logic                                    free_ok_r;
  logic [lockord_pkg::SLOT_BITS-1:0]       free_slot_r;

  logic [lockord_pkg::HELD_DEPTH-1:0]      valid_r;
  logic [lockord_pkg::CLASSES-1:0]         known_r;

  logic                                    accept;
  logic                                    advance;
  logic                                    cur_v;
  logic                                    hit;
  logic                                    known;
  logic [lockord_pkg::LVL_BITS-1:0]        new_lvl;
  logic                                    set_valid;
  logic                                    clr_valid;
  logic [lockord_pkg::SLOT_BITS-1:0]       wr_slot;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_r == S_IDLE);
  assign advance   = (state_r == S_DECIDE) && res_take;
  assign res_valid = (state_r == S_DECIDE);

  assign cur_v = valid_r[{thr_r, chk_r}];
  assign hit   = cur_v && (held_rdata.lock_id == id_r);
  assign known = known_r[cls_r];

  assign held_raddr = (state_r == S_IDLE) ? {req.thread_id, {lockord_pkg::SLOT_BITS{1'b0}}}
                                          : {thr_r, lockord_pkg::SLOT_BITS'(chk_r + 1'b1)};
  assign cls_raddr  = (state_r == S_IDLE) ? req.class_id : cls_r;

  assign new_lvl = !any_r ? '0 :
                   (maxl_r == lockord_pkg::LEVEL_MAX) ? lockord_pkg::LEVEL_MAX :
                   lockord_pkg::LVL_BITS'(maxl_r + 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_r == lockord_pkg::SLOT_BITS'(lockord_pkg::HELD_SLOTS - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status         = lockord_pkg::ST_OK;
    res.hold_count     = '0;
    res.conflict_class = '0;
    res.class_level    = known ? cls_rdata : '0;
    held_wr.we         = 1'b0;
    held_wr.data       = found_word_r;
    wr_slot            = found_slot_r;
    cls_wr.we          = 1'b0;
    cls_wr.addr        = cls_r;
    cls_wr.data        = new_lvl;
    set_valid          = 1'b0;
    clr_valid          = 1'b0;
    if (cmd_r == lockord_pkg::CMD_RELEASE) begin
      if (!found_r) begin
        res.status = lockord_pkg::ST_NOT_HELD;
      end else begin
        res.hold_count     = lockord_pkg::COUNT_BITS'(found_word_r.count - 1'b1);
        held_wr.data.count = res.hold_count;
        held_wr.we         = 1'b1;
        clr_valid          = (res.hold_count == '0);
      end
    end else if (spin_r) begin
      res.status = lockord_pkg::ST_SPIN;
      if (found_r) begin
        res.hold_count = found_word_r.count;
      end
    end else if (found_r) begin
      if (found_word_r.count == lockord_pkg::COUNT_CEIL) begin
        res.status     = lockord_pkg::ST_FULL;
        res.hold_count = found_word_r.count;
      end else begin
        res.hold_count     = lockord_pkg::COUNT_BITS'(found_word_r.count + 1'b1);
        held_wr.data.count = res.hold_count;
        held_wr.we         = 1'b1;
      end
    end else begin
      if (!known) begin
        cls_wr.we       = 1'b1;
        res.class_level = new_lvl;
      end
      if (rev_r) begin
        res.status         = lockord_pkg::ST_REVERSAL;
        res.conflict_class = conflict_r;
      end else if (!free_ok_r) begin
        res.status = lockord_pkg::ST_FULL;
      end else begin
        wr_slot              = free_slot_r;
        held_wr.data.lock_id = id_r;
        held_wr.data.cls     = cls_r;
        held_wr.data.lvl     = res.class_level;
        held_wr.data.count   = lockord_pkg::COUNT_BITS'(1);
        held_wr.we           = 1'b1;
        set_valid            = 1'b1;
        res.hold_count       = lockord_pkg::COUNT_BITS'(1);
      end
    end
    held_wr.addr = {thr_r, wr_slot};
    if (!advance) begin
      held_wr.we = 1'b0;
      cls_wr.we  = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      known_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (set_valid) begin
        valid_r[held_wr.addr] <= 1'b1;
      end
      if (clr_valid) begin
        valid_r[held_wr.addr] <= 1'b0;
      end
      if (cls_wr.we) begin
        known_r[cls_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= req.cmd;
      spin_r    <= req.spinlocks_held;
      thr_r     <= req.thread_id;
      id_r      <= req.lock_id;
      cls_r     <= req.class_id;
      chk_r     <= '0;
      found_r   <= 1'b0;
      any_r     <= 1'b0;
      maxl_r    <= '0;
      rev_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      chk_r <= lockord_pkg::SLOT_BITS'(chk_r + 1'b1);
      if (hit && !found_r) begin
        found_r      <= 1'b1;
        found_slot_r <= chk_r;
        found_word_r <= held_rdata;
      end
      if (cur_v) begin
        any_r <= 1'b1;
        if (held_rdata.lvl > maxl_r) begin
          maxl_r <= held_rdata.lvl;
        end
      end
      if (cur_v && known && !rev_r && (held_rdata.lvl > cls_rdata)) begin
        rev_r      <= 1'b1;
        conflict_r <= held_rdata.cls;
      end
      if (!cur_v && !free_ok_r) begin
        free_ok_r   <= 1'b1;
        free_slot_r <= chk_r;
      end
    end
  end

endmodule

// ----- design/lock_order_checker.sv -----
// Each accepted request is checked by a scan that reads the thread's held-lock memory
//   one slot per cycle, then decided; the result is registered at the output.
// A new request is accepted only after the previous one is decided and its result taken.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, active low) clears the state machine, the held-slot valid bits,
//   the class-known bits and the output valid; memory contents are not cleared.
module lock_order_checker (
  input  logic          clk,
  input  logic          rst_n,
  lockord_req_if.sink   in_chan,
  lockord_rsp_if.source out_chan
);

  logic [lockord_pkg::HELD_ADDR_BITS-1:0] held_raddr;
  lockord_pkg::held_t                     held_rdata;
  lockord_pkg::held_wr_t                  held_wr;
  logic [lockord_pkg::CLS_BITS-1:0]       cls_raddr;
  logic [lockord_pkg::LVL_BITS-1:0]       cls_rdata;
  lockord_pkg::cls_wr_t                   cls_wr;
  logic                                   res_valid;
  logic                                   res_take;
  lockord_pkg::rsp_t                      res;

  logic                                   out_valid_r;
  lockord_pkg::rsp_t                      out_data_r;

  lockord_ram #(
    .WIDTH ($bits(lockord_pkg::held_t)),
    .DEPTH (lockord_pkg::HELD_DEPTH)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_wr.we),
    .waddr (held_wr.addr),
    .wdata (held_wr.data),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  lockord_ram #(
    .WIDTH (lockord_pkg::LVL_BITS),
    .DEPTH (lockord_pkg::CLASSES)
  ) u_cls_ram (
    .clk   (clk),
    .we    (cls_wr.we),
    .waddr (cls_wr.addr),
    .wdata (cls_wr.data),
    .raddr (cls_raddr),
    .rdata (cls_rdata)
  );

  lockord_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_chan),
    .held_raddr (held_raddr),
    .held_rdata (held_rdata),
    .held_wr    (held_wr),
    .cls_raddr  (cls_raddr),
    .cls_rdata  (cls_rdata),
    .cls_wr     (cls_wr),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign res_take = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_data_r.status;
  assign out_chan.class_level    = out_data_r.class_level;
  assign out_chan.hold_count     = out_data_r.hold_count;
  assign out_chan.conflict_class = out_data_r.conflict_class;

endmodule

// ----- design/lockord_chk.sv -----
module lockord_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [lockord_pkg::STATUS_BITS-1:0]   out_status,
  input logic [lockord_pkg::COUNT_BITS-1:0]    out_hold_count,
  input logic [lockord_pkg::CLS_BITS-1:0]      out_conflict_class
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted during scan");

  a_not_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lockord_pkg::ST_NOT_HELD) |-> (out_hold_count == '0))
    else $error("release of unheld lock reports a count");

  a_conflict_only_on_reversal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lockord_pkg::ST_REVERSAL) |-> (out_conflict_class == '0))
    else $error("conflict class without reversal");

endmodule

bind lock_order_checker lockord_chk u_lockord_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_status         (out_chan.status),
  .out_hold_count     (out_chan.hold_count),
  .out_conflict_class (out_chan.conflict_class)
);
